FILE: design/cib_pkg.sv
package cib_pkg;

    // Default widths
    localparam int SAMPLE_BITS_DEF    = 16;
    localparam int COEF_BITS_DEF      = 20;
    localparam int COEF_FRAC_BITS_DEF = 16;

    // Five taps: three feed-forward, two feedback
    localparam int NUM_TAPS  = 5;
    localparam int CFG_IDX_W = 3;

    // Register indexes on the configuration port
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_FEED_TAP0 = 3'd0,
        CFG_FEED_TAP1 = 3'd1,
        CFG_FEED_TAP2 = 3'd2,
        CFG_BACK_TAP1 = 3'd3,
        CFG_BACK_TAP2 = 3'd4
    } t_cfg_idx;

endpackage

FILE: design/complex_iq_biquad_notch.sv
// Direct-form-I biquad for complex I/Q samples, one shared set of five real
// coefficients (three feed-forward, two feedback, signed with COEF_FRAC_BITS
// fraction bits) applied to both rails. One sample beat enters per clock and
// one result beat leaves per clock when the output is not stalled; a sample
// beat waits in the input register and its result in the output register;
// a stalled output also holds the input register. The rate is set by the
// feedback loop: the five multipliers, the adder, rounding and saturation
// of each rail are combinational, so the output history is ready for the
// next sample. Coefficients must be written through the configuration port
// while idle, which the block does not enforce; history resets to zero.
module complex_iq_biquad_notch #(
    parameter int SAMPLE_BITS    = cib_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS      = cib_pkg::COEF_BITS_DEF,
    parameter int COEF_FRAC_BITS = cib_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_stall,
    input  logic signed [SAMPLE_BITS-1:0] i_in_i,
    input  logic signed [SAMPLE_BITS-1:0] i_in_q,
    output logic                          o_valid,
    input  logic                          i_stall,
    output logic signed [SAMPLE_BITS-1:0] o_out_i,
    output logic signed [SAMPLE_BITS-1:0] o_out_q,
    output logic                          o_clipped,
    input  logic                          i_cfg_we,
    input  logic [cib_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COEF_BITS-1:0]          i_cfg_data
);
    import cib_pkg::*;

    logic signed [COEF_BITS-1:0] coef [NUM_TAPS];

    logic r_in_v, r_out_v, n_in_v, n_out_v;
    logic advance, in_acc, step;

    logic signed [SAMPLE_BITS-1:0] r_x_i, r_x_q;
    logic signed [SAMPLE_BITS-1:0] r_x1_i, r_x2_i, r_y1_i, r_y2_i;
    logic signed [SAMPLE_BITS-1:0] r_x1_q, r_x2_q, r_y1_q, r_y2_q;
    logic signed [SAMPLE_BITS-1:0] r_out_i, r_out_q;
    logic                          r_clipped;
    logic signed [SAMPLE_BITS-1:0] n_out_i, n_out_q;
    logic                          sat_i, sat_q;

    cib_coef #(
        .COEF_BITS      (COEF_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_coef (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_coef     (coef)
    );

    cib_rail #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_BITS      (COEF_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_rail_i (
        .i_coef (coef),
        .i_x0   (r_x_i),
        .i_x1   (r_x1_i),
        .i_x2   (r_x2_i),
        .i_y1   (r_y1_i),
        .i_y2   (r_y2_i),
        .o_y    (n_out_i),
        .o_sat  (sat_i)
    );

    cib_rail #(
        .SAMPLE_BITS    (SAMPLE_BITS),
        .COEF_BITS      (COEF_BITS),
        .COEF_FRAC_BITS (COEF_FRAC_BITS)
    ) u_rail_q (
        .i_coef (coef),
        .i_x0   (r_x_q),
        .i_x1   (r_x1_q),
        .i_x2   (r_x2_q),
        .i_y1   (r_y1_q),
        .i_y2   (r_y2_q),
        .o_y    (n_out_q),
        .o_sat  (sat_q)
    );

    // Handshake: the input stage moves on whenever the output register is free
    assign advance = !r_out_v || !i_stall;
    assign o_stall = r_in_v && !advance;
    assign in_acc  = i_valid && !o_stall;
    assign step    = r_in_v && advance;

    assign n_in_v  = in_acc ? 1'b1 : (advance ? 1'b0 : r_in_v);
    assign n_out_v = advance ? r_in_v : r_out_v;

    // Valid flags and filter history
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_v  <= 1'b0;
            r_out_v <= 1'b0;
            r_x1_i  <= '0;
            r_x2_i  <= '0;
            r_y1_i  <= '0;
            r_y2_i  <= '0;
            r_x1_q  <= '0;
            r_x2_q  <= '0;
            r_y1_q  <= '0;
            r_y2_q  <= '0;
        end else begin
            r_in_v  <= n_in_v;
            r_out_v <= n_out_v;
            if (step) begin
                r_x2_i <= r_x1_i;
                r_x1_i <= r_x_i;
                r_y2_i <= r_y1_i;
                r_y1_i <= n_out_i;
                r_x2_q <= r_x1_q;
                r_x1_q <= r_x_q;
                r_y2_q <= r_y1_q;
                r_y1_q <= n_out_q;
            end
        end
    end

    // Payload registers
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_x_i <= i_in_i;
            r_x_q <= i_in_q;
        end
        if (step) begin
            r_out_i   <= n_out_i;
            r_out_q   <= n_out_q;
            r_clipped <= sat_i || sat_q;
        end
    end

    assign o_valid   = r_out_v;
    assign o_out_i   = r_out_i;
    assign o_out_q   = r_out_q;
    assign o_clipped = r_clipped;

endmodule

FILE: design/cib_coef.sv
module cib_coef #(
    parameter int COEF_BITS      = cib_pkg::COEF_BITS_DEF,
    parameter int COEF_FRAC_BITS = cib_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_we,
    input  logic [cib_pkg::CFG_IDX_W-1:0]        i_cfg_idx,
    input  logic [COEF_BITS-1:0]                 i_cfg_data,
    output logic signed [COEF_BITS-1:0]          o_coef [cib_pkg::NUM_TAPS]
);
    import cib_pkg::*;

    // Unity gain on the current input; wraps to -1.0 if COEF_FRAC_BITS is COEF_BITS-1, zero if larger
    localparam logic [COEF_BITS-1:0] COEF_ONE = COEF_BITS'(1) << COEF_FRAC_BITS;

    logic signed [COEF_BITS-1:0] r_coef [NUM_TAPS];

    // Coefficient bank; writes to unused indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef[0] <= $signed(COEF_ONE);
            r_coef[1] <= '0;
            r_coef[2] <= '0;
            r_coef[3] <= '0;
            r_coef[4] <= '0;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_FEED_TAP0: r_coef[0] <= $signed(i_cfg_data);
                CFG_FEED_TAP1: r_coef[1] <= $signed(i_cfg_data);
                CFG_FEED_TAP2: r_coef[2] <= $signed(i_cfg_data);
                CFG_BACK_TAP1: r_coef[3] <= $signed(i_cfg_data);
                CFG_BACK_TAP2: r_coef[4] <= $signed(i_cfg_data);
                default: ;
            endcase
        end
    end

    assign o_coef = r_coef;

endmodule

FILE: design/cib_rail.sv
module cib_rail #(
    parameter int SAMPLE_BITS    = cib_pkg::SAMPLE_BITS_DEF,
    parameter int COEF_BITS      = cib_pkg::COEF_BITS_DEF,
    parameter int COEF_FRAC_BITS = cib_pkg::COEF_FRAC_BITS_DEF
) (
    input  logic signed [COEF_BITS-1:0]   i_coef [cib_pkg::NUM_TAPS],
    input  logic signed [SAMPLE_BITS-1:0] i_x0,
    input  logic signed [SAMPLE_BITS-1:0] i_x1,
    input  logic signed [SAMPLE_BITS-1:0] i_x2,
    input  logic signed [SAMPLE_BITS-1:0] i_y1,
    input  logic signed [SAMPLE_BITS-1:0] i_y2,
    output logic signed [SAMPLE_BITS-1:0] o_y,
    output logic                          o_sat
);
    import cib_pkg::*;

    localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
    // Room for five products, and for the shift to leave a guard bit
    localparam int ACC_A  = PROD_W + 3;
    localparam int ACC_B  = COEF_FRAC_BITS + SAMPLE_BITS + 1;
    localparam int ACC_W  = (ACC_A > ACC_B) ? ACC_A : ACC_B;
    localparam int Q_W    = ACC_W - COEF_FRAC_BITS;

    localparam logic [ACC_W-1:0] RND_HALF = ACC_W'(1) << (COEF_FRAC_BITS - 1);
    localparam logic signed [Q_W-1:0] Q_MAX =
        {{(Q_W-SAMPLE_BITS+1){1'b0}}, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [Q_W-1:0] Q_MIN = ~Q_MAX;

    logic signed [PROD_W-1:0] p0, p1, p2, p3, p4;
    logic signed [ACC_W-1:0]  acc;
    logic        [ACC_W-1:0]  acc_rnd;
    logic signed [Q_W-1:0]    q;

    // Five independent products
    assign p0 = i_coef[0] * i_x0;
    assign p1 = i_coef[1] * i_x1;
    assign p2 = i_coef[2] * i_x2;
    assign p3 = i_coef[3] * i_y1;
    assign p4 = i_coef[4] * i_y2;

    // Exact sum, then round half up and floor to the sample grid
    assign acc     = ACC_W'(p0) + ACC_W'(p1) + ACC_W'(p2) + ACC_W'(p3) + ACC_W'(p4);
    assign acc_rnd = acc + RND_HALF;
    assign q       = $signed(acc_rnd[ACC_W-1:COEF_FRAC_BITS]);

    // Clamp to the sample range
    always_comb begin
        o_sat = 1'b0;
        o_y   = q[SAMPLE_BITS-1:0];
        if (q > Q_MAX) begin
            o_sat = 1'b1;
            o_y   = Q_MAX[SAMPLE_BITS-1:0];
        end else if (q < Q_MIN) begin
            o_sat = 1'b1;
            o_y   = Q_MIN[SAMPLE_BITS-1:0];
        end
    end

endmodule

FILE: design/cib_check.sv
module cib_check #(
    parameter int SAMPLE_BITS = cib_pkg::SAMPLE_BITS_DEF
) (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_valid,
    input logic                          o_stall,
    input logic                          o_valid,
    input logic                          i_stall,
    input logic signed [SAMPLE_BITS-1:0] o_out_i,
    input logic signed [SAMPLE_BITS-1:0] o_out_q,
    input logic                          o_clipped
);
    localparam logic signed [SAMPLE_BITS-1:0] S_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
    localparam logic signed [SAMPLE_BITS-1:0] S_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

    // No result beat straight after reset
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> !o_valid)
        else $error("result beat present after reset");

    // A stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_out_i) && $stable(o_out_q)
            && $stable(o_clipped))
        else $error("stalled result beat changed");

    // Clipping only ever shows with a value at a range end
    a_clip_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_clipped |->
            (o_out_i == S_MAX) || (o_out_i == S_MIN) ||
            (o_out_q == S_MAX) || (o_out_q == S_MIN))
        else $error("clipped flag without a saturated rail");

    // A beat taken while the output is empty reaches the output through the input register
    a_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |-> ##2 o_valid)
        else $error("accepted beat did not reach the output");

endmodule

bind complex_iq_biquad_notch cib_check #(
    .SAMPLE_BITS (SAMPLE_BITS)
) u_cib_check (.*);

FILE: test/tb_complex_iq_biquad_notch.sv
module tb_complex_iq_biquad_notch;

    timeunit 1ns;
    timeprecision 1ps;

    import cib_pkg::*;

    localparam int SW = SAMPLE_BITS_DEF;
    localparam int CW = COEF_BITS_DEF;
    localparam int FB = COEF_FRAC_BITS_DEF;

    localparam longint SAMPLE_MAX = (longint'(1) <<< (SW - 1)) - 1;
    localparam longint SAMPLE_MIN = -(longint'(1) <<< (SW - 1));

    localparam logic signed [CW-1:0] COEF_MAX  = {1'b0, {(CW - 1){1'b1}}};
    localparam logic signed [CW-1:0] COEF_MIN  = {1'b1, {(CW - 1){1'b0}}};
    localparam logic signed [CW-1:0] COEF_ONE  = CW'(longint'(1) <<< FB);
    localparam logic signed [CW-1:0] COEF_HALF = CW'(longint'(1) <<< (FB - 1));
    localparam logic signed [SW-1:0] S_MAX     = SW'(SAMPLE_MAX);
    localparam logic signed [SW-1:0] S_MIN     = SW'(SAMPLE_MIN);

    localparam int PHASE_ITEMS  = 100;
    localparam int NUM_PHASES   = 10;
    localparam int SETTLE_CYC   = 4;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int REPORT_LIMIT = 10;

    typedef struct packed {
        logic signed [SW-1:0] out_i;
        logic signed [SW-1:0] out_q;
        logic                 clipped;
    } t_iq_result;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_valid;
    logic                 o_stall;
    logic signed [SW-1:0] i_in_i;
    logic signed [SW-1:0] i_in_q;
    logic                 o_valid;
    logic                 i_stall;
    logic signed [SW-1:0] o_out_i;
    logic signed [SW-1:0] o_out_q;
    logic                 o_clipped;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_idx;
    logic [CW-1:0]        i_cfg_data;

    // Predictor state: shared coefficients, per-rail history (0 = I, 1 = Q)
    logic signed [CW-1:0] coef_set [NUM_TAPS];
    logic signed [SW-1:0] x_d1 [2];
    logic signed [SW-1:0] x_d2 [2];
    logic signed [SW-1:0] y_d1 [2];
    logic signed [SW-1:0] y_d2 [2];

    t_iq_result due_samples [$];
    t_iq_result want;
    int         mismatches  = 0;
    int         cycle_count = 0;
    bit         bursts_on   = 1'b1;

    complex_iq_biquad_notch u_top (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_stall    (o_stall),
        .i_in_i     (i_in_i),
        .i_in_q     (i_in_q),
        .o_valid    (o_valid),
        .i_stall    (i_stall),
        .o_out_i    (o_out_i),
        .o_out_q    (o_out_q),
        .o_clipped  (o_clipped),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data)
    );

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // Biquad predictor: exact sum, round half up, saturate, update history
    function automatic t_iq_result biquad_step(input logic signed [SW-1:0] in_i,
                                               input logic signed [SW-1:0] in_q);
        t_iq_result           res;
        longint               acc;
        logic signed [SW-1:0] x0;
        logic signed [SW-1:0] y0;
        res = '0;
        for (int r = 0; r < 2; r++) begin
            x0  = (r == 0) ? in_i : in_q;
            acc = longint'(coef_set[CFG_FEED_TAP0]) * longint'(x0)
                + longint'(coef_set[CFG_FEED_TAP1]) * longint'(x_d1[r])
                + longint'(coef_set[CFG_FEED_TAP2]) * longint'(x_d2[r])
                + longint'(coef_set[CFG_BACK_TAP1]) * longint'(y_d1[r])
                + longint'(coef_set[CFG_BACK_TAP2]) * longint'(y_d2[r]);
            acc = (acc + (longint'(1) <<< (FB - 1))) >>> FB;
            if (acc > SAMPLE_MAX) begin
                y0          = S_MAX;
                res.clipped = 1'b1;
            end else if (acc < SAMPLE_MIN) begin
                y0          = S_MIN;
                res.clipped = 1'b1;
            end else begin
                y0 = SW'(acc);
            end
            x_d2[r] = x_d1[r];
            x_d1[r] = x0;
            y_d2[r] = y_d1[r];
            y_d1[r] = y0;
            if (r == 0) res.out_i = y0;
            else        res.out_q = y0;
        end
        return res;
    endfunction

    task automatic flag_error(input string msg);
        mismatches++;
        if (mismatches <= REPORT_LIMIT) $display("%s", msg);
    endtask

    // Result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && !i_stall) begin
            if (due_samples.size() == 0) begin
                flag_error($sformatf("unexpected result beat i=%0d q=%0d clip=%0b",
                                     o_out_i, o_out_q, o_clipped));
            end else begin
                want = due_samples.pop_front();
                if (o_out_i !== want.out_i || o_out_q !== want.out_q ||
                    o_clipped !== want.clipped)
                    flag_error($sformatf(
                        "result mismatch: exp i=%0d q=%0d clip=%0b, got i=%0d q=%0d clip=%0b",
                        want.out_i, want.out_q, want.clipped,
                        o_out_i, o_out_q, o_clipped));
            end
        end
    end

    // Output back-pressure in random bursts
    always begin
        @(posedge i_clk);
        if (bursts_on && $urandom_range(0, 4) == 0) begin
            i_stall <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge i_clk);
            i_stall <= 1'b0;
        end
    end

    // Send one sample beat, with an optional idle burst first
    task automatic send_sample(input logic signed [SW-1:0] si,
                               input logic signed [SW-1:0] sq);
        int gap;
        if (bursts_on && $urandom_range(0, 3) == 0) begin
            gap = $urandom_range(1, 6);
            i_valid <= 1'b0;
            i_in_i  <= SW'($urandom);
            i_in_q  <= SW'($urandom);
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_in_i  <= si;
        i_in_q  <= sq;
        do @(posedge i_clk); while (o_stall);
        due_samples.push_back(biquad_step(si, sq));
    endtask

    // Stop sending and let every outstanding beat come out
    task automatic drain_stream();
        i_valid <= 1'b0;
        while (due_samples.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYC) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] val);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        @(posedge i_clk);
        if (idx < NUM_TAPS) coef_set[idx] = val;
    endtask

    // Idle the block, load all five taps, then poke the unused indexes
    task automatic load_coefs(input logic signed [CW-1:0] c0, c1, c2, d1, d2);
        drain_stream();
        write_reg(CFG_FEED_TAP0, c0);
        write_reg(CFG_FEED_TAP1, c1);
        write_reg(CFG_FEED_TAP2, c2);
        write_reg(CFG_BACK_TAP1, d1);
        write_reg(CFG_BACK_TAP2, d2);
        // writes beyond the last tap must be dropped
        for (int k = NUM_TAPS; k < (1 << CFG_IDX_W); k++)
            write_reg(CFG_IDX_W'(k), CW'($urandom));
        i_cfg_we <= 1'b0;
    endtask

    function automatic logic signed [SW-1:0] pick_sample();
        int sel;
        sel = $urandom_range(0, 19);
        if (sel < 12) return SW'($urandom);
        if (sel < 17) return SW'($signed($urandom_range(0, 1024)) - 512);
        case ($urandom_range(0, 3))
            0:       return S_MAX;
            1:       return S_MIN;
            2:       return '0;
            default: return '1;
        endcase
    endfunction

    function automatic logic signed [CW-1:0] pick_coef(input int style);
        case (style)
            0: return CW'($urandom);
            1: return CW'($signed($urandom_range(0, 2 * int'(COEF_HALF))) - int'(COEF_HALF));
            default: begin
                case ($urandom_range(0, 3))
                    0:       return COEF_MAX;
                    1:       return COEF_MIN;
                    2:       return COEF_ONE;
                    default: return '0;
                endcase
            end
        endcase
    endfunction

    // Reset coefficients give a straight pass-through
    task automatic test_reset_passthrough();
        send_sample(S_MAX, S_MIN);
        send_sample(S_MIN, S_MAX);
        send_sample('0, '1);
        send_sample(16'sh5555, 16'shAAAA);
        send_sample(16'shAAAA, 16'sh5555);
    endtask

    // Half gain: exact ties must round towards plus infinity
    task automatic test_rounding_ties();
        load_coefs(COEF_HALF, '0, '0, '0, '0);
        send_sample(16'sd1, -16'sd1);
        send_sample(16'sd3, -16'sd3);
        send_sample(S_MAX, -S_MAX);
    endtask

    // All taps at either end of the range drive both rails into the rails
    task automatic test_saturation();
        load_coefs(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
        send_sample(S_MAX, S_MIN);
        send_sample(S_MIN, S_MAX);
        send_sample('0, 16'sd1);
        load_coefs(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
        send_sample(S_MAX, S_MIN);
        send_sample(S_MIN, S_MAX);
        send_sample('0, 16'sd1);
    endtask

    // One-tap and two-tap settings show the history ordering of each delay line
    task automatic test_history_taps();
        load_coefs('0, COEF_ONE, '0, '0, '0);
        send_sample(16'sd100, -16'sd7);
        send_sample(16'sd200, -16'sd8);
        send_sample(16'sd300, -16'sd9);
        load_coefs('0, '0, COEF_ONE, '0, COEF_ONE);
        send_sample(16'sd11, 16'sd21);
        send_sample(16'sd12, 16'sd22);
        send_sample(16'sd13, 16'sd23);
    endtask

    // Phases of random traffic under notch, small, wide and extreme settings
    task automatic test_random_phases();
        real                  w;
        real                  rad;
        int                   style;
        logic signed [CW-1:0] c [NUM_TAPS];
        for (int p = 0; p < NUM_PHASES; p++) begin
            style = (p == NUM_PHASES - 1) ? 0 : p % 4;
            if (style == 0) begin
                // well-formed notch: unit zeros on the circle, poles just inside
                w   = 3.14159265 * ($urandom_range(1, 999) / 1000.0);
                rad = 0.80 + 0.19 * ($urandom_range(0, 1000) / 1000.0);
                c[0] = COEF_ONE;
                c[1] = CW'($rtoi(-2.0 * $cos(w) * COEF_ONE));
                c[2] = COEF_ONE;
                c[3] = CW'($rtoi(2.0 * rad * $cos(w) * COEF_ONE));
                c[4] = CW'($rtoi(-rad * rad * COEF_ONE));
            end else begin
                for (int k = 0; k < NUM_TAPS; k++) c[k] = pick_coef(style - 1);
            end
            if (p == NUM_PHASES - 1) begin
                drain_stream();
                bursts_on = 1'b0;
            end
            load_coefs(c[0], c[1], c[2], c[3], c[4]);
            for (int n = 0; n < PHASE_ITEMS; n++)
                send_sample(pick_sample(), pick_sample());
        end
    endtask

    initial begin
        i_rst_n    <= 1'b0;
        i_valid    <= 1'b0;
        i_in_i     <= '0;
        i_in_q     <= '0;
        i_stall    <= 1'b0;
        i_cfg_we   <= 1'b0;
        i_cfg_idx  <= '0;
        i_cfg_data <= '0;
        foreach (coef_set[k]) coef_set[k] = '0;
        coef_set[CFG_FEED_TAP0] = COEF_ONE;
        for (int r = 0; r < 2; r++) begin
            x_d1[r] = '0;
            x_d2[r] = '0;
            y_d1[r] = '0;
            y_d2[r] = '0;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_passthrough();
        test_rounding_ties();
        test_saturation();
        test_history_taps();
        test_random_phases();

        drain_stream();
        repeat (SETTLE_CYC) @(posedge i_clk);
        if (due_samples.size() != 0)
            flag_error($sformatf("%0d result beats never arrived", due_samples.size()));
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
